### design/msps_pkg.sv
// ----------------------------------------------------------------------------
// msps_pkg
// Shared types and constants for the multiplexed servo pulse sequencer.
// ----------------------------------------------------------------------------
package msps_pkg;

    localparam int NUM_CHANNELS = 8;
    localparam int CH_AW        = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SLOT_W       = $clog2(NUM_CHANNELS + 1);

    localparam int CNT_W  = 20;
    localparam int WID_W  = 16;
    localparam int CMD_W  = 2;
    localparam int CH_W   = 4;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [CNT_W-1:0] FRAME_RESET   = CNT_W'(20000);
    localparam logic [WID_W-1:0] DEFAULT_RESET = WID_W'(2500);

    localparam logic [ADDR_W-1:0] REG_FRAME   = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] REG_DEFAULT = ADDR_W'(4);

    typedef enum logic [CMD_W-1:0] {
        CMD_TICK = 2'd0,
        CMD_SET  = 2'd1,
        CMD_STOP = 2'd2,
        CMD_NONE = 2'd3
    } t_cmd;

    typedef struct packed {
        logic            pulse_active;
        logic [CH_W-1:0] pulse_channel;
        logic            running;
        logic            frame_start;
    } t_result;

endpackage

### design/msps_ram.sv
// ----------------------------------------------------------------------------
// msps_ram
// Generic single-write, single-read RAM with registered read data.
// A read of the address being written returns the old contents.
// ----------------------------------------------------------------------------
module msps_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### design/multiplexed_servo_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// multiplexed_servo_pulse_sequencer
// Servo frame sequencer: channel slots in order, then a low complement slot.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one command per transfer:
//   a timer tick, a channel width write or a channel stop. Every input
//   transfer yields exactly one output transfer (o_out_valid / i_out_stall)
//   with the slot status after that command.
//   Status is registered; one command is taken every cycle while o_in_stall
//   is low. Widths live in an 8-entry RAM; the width of a newly entered slot
//   and the old width for the running sum come back in the next cycle and
//   are folded in then, so back-to-back commands never wait.
//   The output register is backed by a one-entry skid buffer: while the
//   receiver stalls, one more command is taken, then o_in_stall rises.
//   Reset stops the sequencer, loads every width with 2500 ticks, the frame
//   with 20000 ticks, and empties both output stages. pready is always high.
//   The APB port writes frame_period_ticks (0x0) and default_width_ticks
//   (0x4); the user must write it only while no transfer is in flight (unchecked).
// ----------------------------------------------------------------------------
module multiplexed_servo_pulse_sequencer (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [msps_pkg::CMD_W-1:0]       i_command,
    input  logic [msps_pkg::CH_W-1:0]        i_channel,
    input  logic [msps_pkg::WID_W-1:0]       i_width_ticks,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic                             o_pulse_active,
    output logic [msps_pkg::CH_W-1:0]        o_pulse_channel,
    output logic                             o_running,
    output logic                             o_frame_start,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [msps_pkg::ADDR_W-1:0]      paddr,
    input  logic [msps_pkg::DATA_W-1:0]      pwdata,
    output logic [msps_pkg::DATA_W-1:0]      prdata,
    output logic                             pready
);
    import msps_pkg::*;

    logic [CNT_W-1:0]        r_frame;
    logic [WID_W-1:0]        r_default;
    logic                    r_active;
    logic [SLOT_W-1:0]       r_slot;
    logic [CNT_W-1:0]        r_cd;
    logic                    r_pend;
    logic                    r_s2;
    logic [WID_W-1:0]        r_s2_w;
    logic [CNT_W-1:0]        r_sum;
    logic [NUM_CHANNELS-1:0] r_nz;
    logic [NUM_CHANNELS-1:0] r_vld;
    logic [WID_W-1:0]        r_fill;
    logic                    r_rd_vld;
    logic [WID_W-1:0]        r_rd_fill;
    t_result                 r_out;
    logic                    r_out_vld;
    t_result                 r_skid;
    logic                    r_skid_vld;

    logic                    n_active;
    logic [SLOT_W-1:0]       n_slot;
    logic [CNT_W-1:0]        n_cd;
    logic                    n_pend;
    logic                    n_s2;
    logic [WID_W-1:0]        n_s2_w;
    logic [CNT_W-1:0]        n_sum;
    logic [NUM_CHANNELS-1:0] n_nz;
    logic [NUM_CHANNELS-1:0] n_vld;
    logic [WID_W-1:0]        n_fill;

    logic                    accept;
    logic                    out_take;
    logic                    cfg_wr;
    t_cmd                    cmd;
    logic                    ch_ok;
    logic [CH_AW-1:0]        ch_a;
    logic [WID_W-1:0]        ram_q;
    logic                    ram_we;
    logic [WID_W-1:0]        ram_wdata;
    logic [CH_AW-1:0]        ram_raddr;
    logic [WID_W-1:0]        old_w;
    logic [CNT_W-1:0]        sum_cur;
    logic [CNT_W-1:0]        cd_cur;
    logic [CNT_W-1:0]        comp_len;
    logic                    found;
    logic [SLOT_W-1:0]       cand;
    logic [SLOT_W:0]         step;
    logic [SLOT_W-1:0]       probe;
    logic                    probe_nz;
    logic [NUM_CHANNELS-1:0] nz_mod;
    logic                    fstart;
    t_result                 res;

    assign cmd    = t_cmd'(i_command);
    assign ch_ok  = (SLOT_W'(i_channel) < SLOT_W'(NUM_CHANNELS)) &&
                    (i_channel < CH_W'(NUM_CHANNELS - 1) || i_channel == CH_W'(NUM_CHANNELS - 1));
    assign ch_a   = CH_AW'(i_channel);
    assign accept = i_in_valid && !r_skid_vld;
    assign out_take = r_out_vld && !i_out_stall;
    assign cfg_wr = psel && penable && pwrite && pready;

    msps_ram #(
        .WIDTH(WID_W),
        .DEPTH(NUM_CHANNELS)
    ) u_width_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ch_a),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_q)
    );

    // width read last cycle: either the slot being entered or the old width of a write
    always_comb begin
        old_w    = r_rd_vld ? ram_q : r_rd_fill;
        sum_cur  = r_s2 ? (r_sum - CNT_W'(old_w) + CNT_W'(r_s2_w)) : r_sum;
        cd_cur   = r_pend ? (CNT_W'(old_w) - CNT_W'(1)) : r_cd;
        comp_len = (sum_cur >= r_frame) ? '0 : (r_frame - sum_cur);
    end

    // next nonzero slot after the current one
    always_comb begin
        found    = 1'b0;
        cand     = r_slot;
        step     = '0;
        probe    = '0;
        probe_nz = 1'b0;
        for (int i = 1; i <= NUM_CHANNELS + 1; i++) begin
            step = (SLOT_W + 1)'(r_slot) + (SLOT_W + 1)'(i);
            if (step >= (SLOT_W + 1)'(NUM_CHANNELS + 1)) begin
                step = step - (SLOT_W + 1)'(NUM_CHANNELS + 1);
            end
            probe    = SLOT_W'(step);
            probe_nz = (probe < SLOT_W'(NUM_CHANNELS)) ? r_nz[CH_AW'(probe)]
                                                       : (comp_len != '0);
            if (!found && probe_nz) begin
                found = 1'b1;
                cand  = probe;
            end
        end
    end

    always_comb begin
        n_active  = r_active;
        n_slot    = r_slot;
        n_cd      = cd_cur;
        n_pend    = 1'b0;
        n_s2      = 1'b0;
        n_s2_w    = r_s2_w;
        n_sum     = sum_cur;
        n_nz      = r_nz;
        n_vld     = r_vld;
        n_fill    = r_fill;
        fstart    = 1'b0;
        ram_we    = 1'b0;
        ram_wdata = (cmd == CMD_SET) ? i_width_ticks : '0;
        ram_raddr = ch_a;
        nz_mod    = r_nz;
        if (accept) begin
            unique case (cmd)
                CMD_SET, CMD_STOP: begin
                    if (ch_ok) begin
                        ram_we       = 1'b1;
                        n_vld[ch_a]  = 1'b1;
                        nz_mod[ch_a] = (ram_wdata != '0);
                        if (nz_mod == '0) begin
                            n_active = 1'b0;
                            n_slot   = '0;
                            n_cd     = '0;
                            n_sum    = CNT_W'(32'(r_default) * NUM_CHANNELS);
                            n_fill   = r_default;
                            n_nz     = {NUM_CHANNELS{r_default != '0}};
                            n_vld    = '0;
                        end else begin
                            n_nz   = nz_mod;
                            n_s2   = 1'b1;
                            n_s2_w = ram_wdata;
                            if (!r_active) begin
                                n_active = 1'b1;
                                n_slot   = SLOT_W'(NUM_CHANNELS);
                                n_cd     = '0;
                            end
                        end
                    end
                end
                CMD_TICK: begin
                    if (r_active) begin
                        if (cd_cur == '0) begin
                            if (found) begin
                                n_slot    = cand;
                                ram_raddr = CH_AW'(cand);
                                fstart    = (cand <= r_slot) &&
                                            (cand < SLOT_W'(NUM_CHANNELS));
                                if (cand < SLOT_W'(NUM_CHANNELS)) begin
                                    n_pend = 1'b1;
                                    n_cd   = '0;
                                end else begin
                                    n_cd = comp_len - CNT_W'(1);
                                end
                            end else begin
                                n_slot = SLOT_W'(NUM_CHANNELS);
                            end
                        end else begin
                            n_cd = cd_cur - CNT_W'(1);
                        end
                    end
                end
                CMD_NONE: begin
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        res.running       = n_active;
        res.pulse_active  = n_active && (n_slot < SLOT_W'(NUM_CHANNELS));
        res.pulse_channel = res.pulse_active ? CH_W'(n_slot) : '0;
        res.frame_start   = fstart;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame    <= FRAME_RESET;
            r_default  <= DEFAULT_RESET;
            r_active   <= 1'b0;
            r_slot     <= '0;
            r_cd       <= '0;
            r_pend     <= 1'b0;
            r_s2       <= 1'b0;
            r_sum      <= CNT_W'(32'(DEFAULT_RESET) * NUM_CHANNELS);
            r_nz       <= {NUM_CHANNELS{1'b1}};
            r_vld      <= '0;
            r_fill     <= DEFAULT_RESET;
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            if (cfg_wr && paddr == REG_FRAME) begin
                r_frame <= CNT_W'(pwdata);
            end
            if (cfg_wr && paddr == REG_DEFAULT) begin
                r_default <= WID_W'(pwdata);
            end
            r_active <= n_active;
            r_slot   <= n_slot;
            r_cd     <= n_cd;
            r_pend   <= n_pend;
            r_s2     <= n_s2;
            r_sum    <= n_sum;
            r_nz     <= n_nz;
            r_vld    <= n_vld;
            r_fill   <= n_fill;
            if (out_take || !r_out_vld) begin
                if (r_skid_vld) begin
                    r_out_vld  <= 1'b1;
                    r_skid_vld <= 1'b0;
                end else begin
                    r_out_vld <= accept;
                end
            end else if (accept) begin
                r_skid_vld <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_w    <= n_s2_w;
        r_rd_vld  <= r_vld[ram_raddr];
        r_rd_fill <= r_fill;
        if (out_take || !r_out_vld) begin
            r_out <= r_skid_vld ? r_skid : res;
        end else if (accept) begin
            r_skid <= res;
        end
    end

    assign o_in_stall      = r_skid_vld;
    assign o_out_valid     = r_out_vld;
    assign o_pulse_active  = r_out.pulse_active;
    assign o_pulse_channel = r_out.pulse_channel;
    assign o_running       = r_out.running;
    assign o_frame_start   = r_out.frame_start;
    assign pready          = 1'b1;

    always_comb begin
        if (paddr == REG_FRAME) begin
            prdata = DATA_W'(r_frame);
        end else if (paddr == REG_DEFAULT) begin
            prdata = DATA_W'(r_default);
        end else begin
            prdata = '0;
        end
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid entry held with empty output register");

    a_pend_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_active && r_slot < SLOT_W'(NUM_CHANNELS) && r_nz[CH_AW'(r_slot)]))
        else $error("slot width load pending outside an active channel slot");

    a_sum_update_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2 |-> (r_active && r_nz != '0))
        else $error("width sum update after the sequencer stopped");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(NUM_CHANNELS))
        else $error("slot index out of range");

    a_fstart_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_frame_start) |-> (o_pulse_active && o_running))
        else $error("frame start outside a channel slot");

endmodule

### tb/tb_multiplexed_servo_pulse_sequencer.sv
// ----------------------------------------------------------------------------
// tb_multiplexed_servo_pulse_sequencer
// Self-checking bench for the servo frame sequencer. A queue of tick, set
// and stop commands feeds a valid/stall driver. A command-level predictor
// tracks the width table, running sum, slot and countdown, and computes the
// status that each command transfer should produce. A monitor compares every
// output transfer with the oldest prediction. Frame and default widths are
// changed over APB between phases, including maximum values and a zero default.
// ----------------------------------------------------------------------------
module tb_multiplexed_servo_pulse_sequencer;
    import msps_pkg::*;

    typedef struct {
        t_cmd             cmd;
        logic [CH_W-1:0]  ch;
        logic [WID_W-1:0] w;
    } servo_cmd_t;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_stall;
    logic [CMD_W-1:0]  i_command = CMD_NONE;
    logic [CH_W-1:0]   i_channel = '0;
    logic [WID_W-1:0]  i_width_ticks = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    logic              o_pulse_active;
    logic [CH_W-1:0]   o_pulse_channel;
    logic              o_running;
    logic              o_frame_start;
    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    multiplexed_servo_pulse_sequencer dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_command       (i_command),
        .i_channel       (i_channel),
        .i_width_ticks   (i_width_ticks),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_pulse_active  (o_pulse_active),
        .o_pulse_channel (o_pulse_channel),
        .o_running       (o_running),
        .o_frame_start   (o_frame_start),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    servo_cmd_t cmd_backlog[$];
    t_result    status_due[$];
    int         mismatches = 0;
    int         cycle_no = 0;
    wire        calm = (cycle_no >= 200) && (cycle_no < 450);

    // predicted sequencer state and configuration
    logic [WID_W-1:0] width_mem [NUM_CHANNELS];
    logic [CNT_W-1:0] sum_ticks;
    int               live_channels;
    int               cur_slot;
    logic [CNT_W-1:0] slot_left;
    bit               seq_on;
    logic [CNT_W-1:0] frame_cfg;
    logic [WID_W-1:0] default_cfg;

    function automatic logic [CNT_W-1:0] slot_ticks(int s);
        if (s < NUM_CHANNELS) return CNT_W'(width_mem[s]);
        if (sum_ticks >= frame_cfg) return '0;
        return frame_cfg - sum_ticks;
    endfunction

    function automatic void halt_all();
        for (int i = 0; i < NUM_CHANNELS; i++) width_mem[i] = default_cfg;
        sum_ticks = CNT_W'(default_cfg * NUM_CHANNELS);
        live_channels = (default_cfg != 0) ? NUM_CHANNELS : 0;
        seq_on = 1'b0;
        cur_slot = 0;
        slot_left = '0;
    endfunction

    function automatic void store_width(int ch, logic [WID_W-1:0] w);
        logic [WID_W-1:0] old;
        old = width_mem[ch];
        sum_ticks = sum_ticks - CNT_W'(old) + CNT_W'(w);
        if (old != 0 && w == 0) live_channels--;
        else if (old == 0 && w != 0) live_channels++;
        width_mem[ch] = w;
        if (live_channels == 0) begin
            halt_all();
        end else if (!seq_on) begin
            seq_on = 1'b1;
            cur_slot = NUM_CHANNELS;
            slot_left = '0;
        end
    endfunction

    function automatic t_result advance_sequencer(servo_cmd_t c);
        t_result r;
        int      cand;
        bit      crossed;
        bit      found;
        r = '0;
        crossed = 1'b0;
        found = 1'b0;
        cand = cur_slot;
        if (c.cmd == CMD_SET || c.cmd == CMD_STOP) begin
            if (c.ch < NUM_CHANNELS)
                store_width(int'(c.ch), (c.cmd == CMD_SET) ? c.w : WID_W'(0));
        end else if (c.cmd == CMD_TICK && seq_on) begin
            if (slot_left == 0) begin
                for (int i = 1; i <= NUM_CHANNELS + 1 && !found; i++) begin
                    cand = (cur_slot + i) % (NUM_CHANNELS + 1);
                    if (cand == 0) crossed = 1'b1;
                    if (slot_ticks(cand) != 0) found = 1'b1;
                end
                if (found) begin
                    cur_slot = cand;
                    slot_left = slot_ticks(cand);
                    r.frame_start = crossed && (cand < NUM_CHANNELS);
                end else begin
                    cur_slot = NUM_CHANNELS;
                end
            end
            if (slot_left != 0) slot_left--;
        end
        r.running = seq_on;
        r.pulse_active = seq_on && (cur_slot < NUM_CHANNELS);
        r.pulse_channel = r.pulse_active ? CH_W'(cur_slot) : '0;
        return r;
    endfunction

    // command driver; the prediction is made on each input transfer
    always @(posedge i_clk) begin
        servo_cmd_t nxt;
        servo_cmd_t cur;
        cycle_no <= cycle_no + 1;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                cur.cmd = t_cmd'(i_command);
                cur.ch = i_channel;
                cur.w = i_width_ticks;
                status_due.push_back(advance_sequencer(cur));
            end
            if (!i_in_valid || !o_in_stall) begin
                if (cmd_backlog.size() > 0 && (calm || $urandom_range(99) >= 16)) begin
                    nxt = cmd_backlog.pop_front();
                    i_command <= nxt.cmd;
                    i_channel <= nxt.ch;
                    i_width_ticks <= nxt.w;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // status monitor
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (status_due.size() == 0) begin
                $display("%0t: unexpected status transfer", $time);
                mismatches++;
            end else begin
                want = status_due.pop_front();
                if (o_pulse_active !== want.pulse_active) begin
                    $display("%0t: pulse_active expected %0d actual %0d",
                             $time, want.pulse_active, o_pulse_active);
                    mismatches++;
                end
                if (o_pulse_channel !== want.pulse_channel) begin
                    $display("%0t: pulse_channel expected %0d actual %0d",
                             $time, want.pulse_channel, o_pulse_channel);
                    mismatches++;
                end
                if (o_running !== want.running) begin
                    $display("%0t: running expected %0d actual %0d",
                             $time, want.running, o_running);
                    mismatches++;
                end
                if (o_frame_start !== want.frame_start) begin
                    $display("%0t: frame_start expected %0d actual %0d",
                             $time, want.frame_start, o_frame_start);
                    mismatches++;
                end
            end
        end
        i_out_stall <= !calm && ($urandom_range(99) < 16);
    end

    function automatic void queue_cmd(t_cmd c, int ch, int w);
        servo_cmd_t s;
        s.cmd = c;
        s.ch = CH_W'(ch);
        s.w = WID_W'(w);
        cmd_backlog.push_back(s);
    endfunction

    function automatic int short_width();
        return ($urandom_range(4) == 0) ? 0 : $urandom_range(1, 5);
    endfunction

    function automatic void queue_ticks(int n);
        for (int i = 0; i < n; i++) queue_cmd(CMD_TICK, 0, 0);
    endfunction

    function automatic void queue_reprogram();
        for (int ch = 0; ch < NUM_CHANNELS; ch++) queue_cmd(CMD_SET, ch, short_width());
    endfunction

    function automatic void queue_random(int n);
        int made;
        int pick;
        int k;
        int ch;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(99);
            ch = $urandom_range(NUM_CHANNELS - 1);
            if (pick < 48) begin
                k = $urandom_range(1, 12);
                queue_ticks(k);
                made += k;
            end else if (pick < 66) begin
                queue_cmd(CMD_SET, ch, ($urandom_range(4) == 0) ?
                          $urandom_range(0, 40) : $urandom_range(0, 6));
                made++;
            end else if (pick < 73) begin
                queue_cmd(CMD_STOP, ch, $urandom_range(0, 65535));
                made++;
            end else if (pick < 83) begin
                // ignored: unused command or channel out of range
                k = $urandom_range(2);
                queue_cmd((k == 0) ? CMD_NONE : (k == 1) ? CMD_SET : CMD_STOP,
                          (k == 0) ? $urandom_range(15) : $urandom_range(NUM_CHANNELS, 15),
                          $urandom_range(0, 65535));
            end else if (pick < 89) begin
                // wide value, replaced before the slot can load it
                queue_cmd(CMD_SET, ch, $urandom_range(0, 65535));
                queue_cmd(CMD_SET, ch, short_width());
                made += 2;
            end else begin
                for (int i = 0; i < NUM_CHANNELS; i++) queue_cmd(CMD_STOP, i, 0);
                queue_reprogram();
                made += 2 * NUM_CHANNELS;
            end
        end
    endfunction

    task automatic wait_drained();
        @(negedge i_clk);
        while (cmd_backlog.size() != 0 || status_due.size() != 0 || i_in_valid)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic apb_write(logic [ADDR_W-1:0] addr, logic [DATA_W-1:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic configure(logic [CNT_W-1:0] frame, logic [WID_W-1:0] dflt);
        wait_drained();
        apb_write(REG_FRAME, DATA_W'(frame));
        frame_cfg = frame;
        apb_write(REG_DEFAULT, DATA_W'(dflt));
        default_cfg = dflt;
    endtask

    initial begin
        frame_cfg = FRAME_RESET;
        default_cfg = DEFAULT_RESET;
        halt_all();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset configuration
        queue_cmd(CMD_TICK, 0, 0);
        queue_cmd(CMD_NONE, 15, 16'hFFFF);
        queue_cmd(CMD_SET, 8, 16'hFFFF);
        queue_cmd(CMD_STOP, 15, 0);
        queue_cmd(CMD_SET, 0, 2);
        queue_cmd(CMD_SET, 3, 16'hFFFF);
        queue_cmd(CMD_SET, 3, 1);
        queue_cmd(CMD_SET, 1, 0);
        queue_cmd(CMD_SET, 2, 1);
        queue_cmd(CMD_SET, 4, 1);
        queue_cmd(CMD_SET, 5, 0);
        queue_cmd(CMD_SET, 6, 0);
        queue_cmd(CMD_SET, 7, 1);
        queue_ticks(1);
        queue_cmd(CMD_SET, 0, 4);
        queue_ticks(4);
        queue_cmd(CMD_STOP, 2, 0);
        queue_ticks(3);
        queue_random(60);

        // short frame, sum often above it
        configure(20'd12, 16'd3);
        queue_reprogram();
        queue_random(75);
        wait_drained();
        queue_random(75);

        // one-tick frame, zero default
        configure(20'd1, 16'd0);
        queue_random(130);

        // maximum frame and default
        configure(20'hFFFFF, 16'hFFFF);
        queue_reprogram();
        queue_random(60);

        configure(20'd25, 16'd1);
        queue_reprogram();
        queue_random(120);

        wait_drained();
        repeat (5) @(negedge i_clk);
        if (mismatches == 0) begin
            $display("multiplexed_servo_pulse_sequencer verification clean");
        end else begin
            $display("multiplexed_servo_pulse_sequencer verification failed");
        end
        $finish;
    end

    initial begin
        #8000000;
        $display("multiplexed_servo_pulse_sequencer verification failed");
        $finish;
    end

endmodule

### filelist.f
design/msps_pkg.sv
design/msps_ram.sv
design/multiplexed_servo_pulse_sequencer.sv
tb/tb_multiplexed_servo_pulse_sequencer.sv
